/* hdl/assert_macros.svh */
// assertion macros shared by the checker files
// every macro samples on clk and is disabled while rst is high

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/s2f_pkg.sv */
// shared types, constants and the month length table for seconds_to_fat_timestamp
// no dependencies
`timescale 1ns / 1ps

package s2f_pkg;

  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned YOFF_W   = 8;

  localparam logic [11:0] BASE_YEAR     = 12'd1950;
  localparam logic [11:0] FAT_BASE_YEAR = 12'd1980;
  localparam logic [YOFF_W-1:0] FAT_YEAR_OFS = 8'd30;

  localparam logic [UNIT_W-1:0] DIV_SEC   = 16'd60;
  localparam logic [UNIT_W-1:0] DIV_HOUR  = 16'd24;
  localparam logic [UNIT_W-1:0] QUAD_DAYS = 16'd1461;
  localparam logic [UNIT_W-1:0] DAYS_YEAR = 16'd365;
  localparam logic [UNIT_W-1:0] DAYS_LEAP = 16'd366;

  // reciprocals for exact 32-bit division by 60 and by 24
  localparam logic [EPOCH_W-1:0] RECIP_SEC  = 32'h8888_8889;
  localparam logic [EPOCH_W-1:0] RECIP_HOUR = 32'hAAAA_AAAB;
  localparam int unsigned        SHIFT_SEC  = 37;
  localparam int unsigned        SHIFT_HOUR = 36;

  localparam logic [3:0] MON_FEB  = 4'd1;
  localparam logic [3:0] MON_APR  = 4'd3;
  localparam logic [3:0] MON_JUN  = 4'd5;
  localparam logic [3:0] MON_SEP  = 4'd8;
  localparam logic [3:0] MON_NOV  = 4'd10;
  localparam logic [3:0] MON_DEC  = 4'd11;

  // offset from 1950 whose low bits mark a leap year
  localparam logic [1:0] LEAP_PHASE = 2'd2;

  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } s2f_sub_req_t;

  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } s2f_sub_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } s2f_seq_ctl_t;

  typedef struct packed {
    logic [YOFF_W-1:0] yoff;
    logic [3:0]        mon;
    logic [4:0]        mday;
    logic [4:0]        hr;
    logic [5:0]        min;
    logic [5:0]        sec;
  } s2f_result_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/s2f_if.sv */
// request and response channel interfaces for seconds_to_fat_timestamp
// no dependencies
`timescale 1ns / 1ps

interface s2f_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface s2f_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] fat_stamp;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        before_fat_epoch;

  modport source(output valid, output fat_stamp, output year, output month,
                 output day_of_month, output hour, output minute, output second,
                 output before_fat_epoch, input ready);
  modport sink(input valid, input fat_stamp, input year, input month,
               input day_of_month, input hour, input minute, input second,
               input before_fat_epoch, output ready);
endinterface

/* hdl/seconds_to_fat_timestamp.sv */
// top level: request intake, sequencer, field packing and response register
// depends on s2f_pkg, s2f_if, s2f_seq
//
//   channel    dir  payload
//   stamp_in   in   epoch_seconds
//   stamp_out  out  fat_stamp, year, month, day_of_month, hour, minute,
//                   second, before_fat_epoch
//
// each request runs through three reciprocal divisions (by 60, 60, 24),
// up to 35 steps over four-year blocks, up to four year steps and up to
// twelve month steps, the remainders and walks all on the one 16-bit
// compare and subtract unit
// stamp_in.ready is high only while the sequencer is idle
// a finished response waits in the output register; a new request may be
// taken meanwhile, and the sequencer holds its result until the register frees
// synchronous reset clears the sequencer state and the response valid
`timescale 1ns / 1ps

module seconds_to_fat_timestamp (
  input  logic       clk,
  input  logic       rst,
  s2f_req_if.sink    stamp_in,
  s2f_rsp_if.source  stamp_out
);
  import s2f_pkg::*;

  s2f_seq_ctl_t ctl;
  s2f_result_t  result;
  logic         start;
  logic         take;

  logic         rsp_valid;
  logic [31:0]  rsp_stamp;
  logic [11:0]  rsp_year;
  logic [3:0]   rsp_month;
  logic [4:0]   rsp_day;
  logic [4:0]   rsp_hour;
  logic [5:0]   rsp_minute;
  logic [5:0]   rsp_second;
  logic         rsp_before;

  logic [11:0]  year_next;
  logic [3:0]   month_next;
  logic [4:0]   day_next;
  logic         before_next;
  logic [6:0]   yfield_next;

  assign stamp_in.ready = ctl.idle;
  assign start          = stamp_in.valid & ctl.idle;
  assign take           = ctl.done & (~rsp_valid | stamp_out.ready);

  s2f_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .epoch  (stamp_in.epoch_seconds),
    .take   (take),
    .ctl    (ctl),
    .result (result)
  );

  assign year_next   = BASE_YEAR + {4'd0, result.yoff};
  assign month_next  = result.mon + 1'b1;
  assign day_next    = result.mday + 1'b1;
  assign before_next = (result.yoff < FAT_YEAR_OFS);
  assign yfield_next = before_next ? 7'd0 : 7'(result.yoff - FAT_YEAR_OFS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (stamp_out.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_stamp  <= {yfield_next, month_next, day_next, result.hr, result.min,
                     result.sec[5:1]};
      rsp_year   <= year_next;
      rsp_month  <= month_next;
      rsp_day    <= day_next;
      rsp_hour   <= result.hr;
      rsp_minute <= result.min;
      rsp_second <= result.sec;
      rsp_before <= before_next;
    end
  end

  assign stamp_out.valid            = rsp_valid;
  assign stamp_out.fat_stamp        = rsp_stamp;
  assign stamp_out.year             = rsp_year;
  assign stamp_out.month            = rsp_month;
  assign stamp_out.day_of_month     = rsp_day;
  assign stamp_out.hour             = rsp_hour;
  assign stamp_out.minute           = rsp_minute;
  assign stamp_out.second           = rsp_second;
  assign stamp_out.before_fat_epoch = rsp_before;

endmodule

/* hdl/s2f_sub_unit.sv */
// shared 16-bit compare and subtract unit
// depends on s2f_pkg
`timescale 1ns / 1ps

module s2f_sub_unit (
  input  s2f_pkg::s2f_sub_req_t req,
  output s2f_pkg::s2f_sub_rsp_t rsp
);
  import s2f_pkg::*;

  logic [UNIT_W:0] wide;

  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.ge   = ~wide[UNIT_W];
  assign rsp.diff = wide[UNIT_W-1:0];

endmodule

/* hdl/s2f_seq.sv */
// sequencer: three reciprocal divisions, year and month walks on the shared unit
// depends on s2f_pkg and s2f_sub_unit
`timescale 1ns / 1ps

module s2f_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [s2f_pkg::EPOCH_W-1:0]  epoch,
  input  logic                         take,
  output s2f_pkg::s2f_seq_ctl_t        ctl,
  output s2f_pkg::s2f_result_t         result
);
  import s2f_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_QUAD = 3'd2;
  localparam logic [2:0] S_YEAR = 3'd3;
  localparam logic [2:0] S_MON  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] DSEL_SEC  = 2'd0;
  localparam logic [1:0] DSEL_MIN  = 2'd1;
  localparam logic [1:0] DSEL_HOUR = 2'd2;

  logic [2:0]          state;
  logic                phase;
  logic [1:0]          dsel;
  logic [EPOCH_W-1:0]  work;
  logic [EPOCH_W-1:0]  quo;
  logic [5:0]          sec;
  logic [5:0]          min;
  logic [4:0]          hr;
  logic [UNIT_W-1:0]   days;
  logic [YOFF_W-1:0]   yoff;
  logic [3:0]          mon;

  logic [2*EPOCH_W-1:0] prod;
  logic [EPOCH_W-1:0]   recip;
  logic [EPOCH_W-1:0]   quo_next;
  logic [UNIT_W-1:0]    divisor;
  logic                 leap;
  s2f_sub_req_t         sub_req;
  s2f_sub_rsp_t         sub_rsp;

  s2f_sub_unit u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  assign leap    = (yoff[1:0] == LEAP_PHASE);
  assign divisor = (dsel == DSEL_HOUR) ? DIV_HOUR : DIV_SEC;
  assign recip   = (dsel == DSEL_HOUR) ? RECIP_HOUR : RECIP_SEC;

  // quotient by reciprocal multiplication, remainder on the shared unit next cycle
  assign prod     = {{EPOCH_W{1'b0}}, work} * {{EPOCH_W{1'b0}}, recip};
  assign quo_next = (dsel == DSEL_HOUR) ? EPOCH_W'(prod >> SHIFT_HOUR)
                                        : EPOCH_W'(prod >> SHIFT_SEC);

  always_comb begin
    sub_req.a = '0;
    sub_req.b = '0;
    unique case (state)
      S_DIV: begin
        sub_req.a = work[UNIT_W-1:0];
        sub_req.b = quo[UNIT_W-1:0] * divisor;
      end
      S_QUAD: begin
        sub_req.a = days;
        sub_req.b = QUAD_DAYS;
      end
      S_YEAR: begin
        sub_req.a = days;
        sub_req.b = leap ? DAYS_LEAP : DAYS_YEAR;
      end
      S_MON: begin
        sub_req.a = days;
        sub_req.b = {{(UNIT_W-5){1'b0}}, month_len(mon, leap)};
      end
      default: begin
        sub_req.a = '0;
        sub_req.b = '0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      dsel  <= DSEL_SEC;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DIV;
            phase <= 1'b0;
            dsel  <= DSEL_SEC;
          end
        end
        S_DIV: begin
          phase <= ~phase;
          if (phase) begin
            if (dsel == DSEL_HOUR) begin
              state <= S_QUAD;
            end else begin
              dsel <= dsel + 1'b1;
            end
          end
        end
        S_QUAD: begin
          if (!sub_rsp.ge) begin
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (!sub_rsp.ge) begin
            state <= S_MON;
          end
        end
        S_MON: begin
          if (!sub_rsp.ge || mon == MON_DEC) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          work <= epoch;
        end
      end
      S_DIV: begin
        if (!phase) begin
          quo <= quo_next;
        end else begin
          work <= quo;
          unique case (dsel)
            DSEL_SEC: sec <= sub_rsp.diff[5:0];
            DSEL_MIN: min <= sub_rsp.diff[5:0];
            default: begin
              hr   <= sub_rsp.diff[4:0];
              days <= quo[UNIT_W-1:0];
              yoff <= '0;
            end
          endcase
        end
      end
      S_QUAD: begin
        if (sub_rsp.ge) begin
          days <= sub_rsp.diff;
          yoff <= yoff + YOFF_W'(4);
        end
      end
      S_YEAR: begin
        if (sub_rsp.ge) begin
          days <= sub_rsp.diff;
          yoff <= yoff + 1'b1;
        end else begin
          mon <= '0;
        end
      end
      S_MON: begin
        if (sub_rsp.ge && mon != MON_DEC) begin
          days <= sub_rsp.diff;
          mon  <= mon + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.idle = (state == S_IDLE);
  assign ctl.done = (state == S_DONE);

  assign result.yoff = yoff;
  assign result.mon  = mon;
  assign result.mday = days[4:0];
  assign result.hr   = hr;
  assign result.min  = min;
  assign result.sec  = sec;

endmodule

/* hdl/s2f_checker.sv */
// port-level checker for seconds_to_fat_timestamp and its bind
// depends on s2f_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s2f_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] fat_stamp,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic        before_fat_epoch
);
  import s2f_pkg::*;

  `ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready, "ready after request")

  `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(fat_stamp), "stalled response changed")

  `ASSERT_IMPLIES(a_stamp_fields, out_valid, fat_stamp[24:21] == month && fat_stamp[20:16] == day_of_month && fat_stamp[15:11] == hour && fat_stamp[10:5] == minute && fat_stamp[4:0] == second[5:1], "stamp fields disagree")

  `ASSERT_IMPLIES(a_epoch_flag, out_valid, (before_fat_epoch == (year < FAT_BASE_YEAR)) && (!before_fat_epoch || fat_stamp[31:25] == 7'd0), "epoch flag or year field wrong")

  `ASSERT_IMPLIES(a_time_ranges, out_valid, month != 4'd0 && month <= 4'd12 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "field out of range")

endmodule

bind seconds_to_fat_timestamp s2f_checker u_s2f_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (stamp_in.valid),
  .in_ready         (stamp_in.ready),
  .out_valid        (stamp_out.valid),
  .out_ready        (stamp_out.ready),
  .fat_stamp        (stamp_out.fat_stamp),
  .year             (stamp_out.year),
  .month            (stamp_out.month),
  .day_of_month     (stamp_out.day_of_month),
  .hour             (stamp_out.hour),
  .minute           (stamp_out.minute),
  .second           (stamp_out.second),
  .before_fat_epoch (stamp_out.before_fat_epoch)
);

/* verif/tb_top.sv */
// self-checking testbench for seconds_to_fat_timestamp: directed and random epoch counts
// depends on s2f_pkg, s2f_if and the seconds_to_fat_timestamp rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TOTAL_REQUESTS = 1700;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned LAST_DAY       = 49710;

  typedef struct {
    logic [31:0] fat_stamp;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        pre_fat;
  } stamp_fields_t;

  class fat_stamp_scoreboard;
    stamp_fields_t due_q[$];
    int unsigned   mismatches;

    // m counts from 0 for january
    static function int unsigned month_days(int unsigned y, int unsigned m);
      if (m == s2f_pkg::MON_FEB) begin
        return (y % 4 == 0) ? 29 : 28;
      end
      if (m == s2f_pkg::MON_APR || m == s2f_pkg::MON_JUN ||
          m == s2f_pkg::MON_SEP || m == s2f_pkg::MON_NOV) begin
        return 30;
      end
      return 31;
    endfunction

    function stamp_fields_t calendar_of(bit [31:0] secs);
      stamp_fields_t f;
      bit [31:0]     t;
      int unsigned   days, yr, mon, sec, mins, hr;
      bit [6:0]      yfield;
      t    = secs;
      sec  = t % 60;
      t    = t / 60;
      mins = t % 60;
      t    = t / 60;
      hr   = t % 24;
      days = t / 24;
      yr   = s2f_pkg::BASE_YEAR;
      while (days >= ((yr % 4 == 0) ? 366 : 365)) begin
        days -= (yr % 4 == 0) ? 366 : 365;
        yr++;
      end
      mon = 0;
      while (mon < s2f_pkg::MON_DEC && days >= month_days(yr, mon)) begin
        days -= month_days(yr, mon);
        mon++;
      end
      f.pre_fat   = (yr < s2f_pkg::FAT_BASE_YEAR);
      yfield      = f.pre_fat ? 7'd0 : 7'(yr - s2f_pkg::FAT_BASE_YEAR);
      f.year      = 12'(yr);
      f.month     = 4'(mon + 1);
      f.mday      = 5'(days + 1);
      f.hour      = 5'(hr);
      f.minute    = 6'(mins);
      f.second    = 6'(sec);
      f.fat_stamp = {yfield, f.month, f.mday, f.hour, f.minute, f.second[5:1]};
      return f;
    endfunction

    function void note_request(bit [31:0] secs);
      due_q.push_back(calendar_of(secs));
    endfunction

    function void report(string field, longint unsigned exp_v, longint unsigned got_v);
      mismatches++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, field, exp_v, got_v);
    endfunction

    function void check_response(stamp_fields_t got);
      stamp_fields_t exp_f;
      if (due_q.size() == 0) begin
        report("unrequested stamp", 0, got.fat_stamp);
        return;
      end
      exp_f = due_q.pop_front();
      if (got.fat_stamp !== exp_f.fat_stamp) report("fat_stamp", exp_f.fat_stamp, got.fat_stamp);
      if (got.year !== exp_f.year)           report("year", exp_f.year, got.year);
      if (got.month !== exp_f.month)         report("month", exp_f.month, got.month);
      if (got.mday !== exp_f.mday)           report("day_of_month", exp_f.mday, got.mday);
      if (got.hour !== exp_f.hour)           report("hour", exp_f.hour, got.hour);
      if (got.minute !== exp_f.minute)       report("minute", exp_f.minute, got.minute);
      if (got.second !== exp_f.second)       report("second", exp_f.second, got.second);
      if (got.pre_fat !== exp_f.pre_fat)     report("before_fat_epoch", exp_f.pre_fat, got.pre_fat);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  s2f_req_if stamp_in();
  s2f_rsp_if stamp_out();

  seconds_to_fat_timestamp i_dut (
    .clk       (clk),
    .rst       (rst),
    .stamp_in  (stamp_in),
    .stamp_out (stamp_out)
  );

  fat_stamp_scoreboard sb = new();

  int unsigned   requests_sent;
  int unsigned   quiet_cycles;
  bit            idling_on;
  bit            hold_request;
  stamp_fields_t seen_rsp;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // monitor: requests before responses, both sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (stamp_in.valid && stamp_in.ready) begin
        sb.note_request(stamp_in.epoch_seconds);
      end
      if (stamp_out.valid && stamp_out.ready) begin
        seen_rsp.fat_stamp = stamp_out.fat_stamp;
        seen_rsp.year      = stamp_out.year;
        seen_rsp.month     = stamp_out.month;
        seen_rsp.mday      = stamp_out.day_of_month;
        seen_rsp.hour      = stamp_out.hour;
        seen_rsp.minute    = stamp_out.minute;
        seen_rsp.second    = stamp_out.second;
        seen_rsp.pre_fat   = stamp_out.before_fat_epoch;
        sb.check_response(seen_rsp);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (stamp_in.valid && stamp_in.ready) || (stamp_out.valid && stamp_out.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // response side: random stalls, one long hold on request
  initial begin
    stamp_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        stamp_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stamp_out.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        stamp_out.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // start of year y, month m (0 based) in whole days
  function automatic longint unsigned month_start_day(int unsigned y, int unsigned m);
    longint unsigned d;
    d = 0;
    for (int unsigned yy = s2f_pkg::BASE_YEAR; yy < y; yy++) begin
      d += (yy % 4 == 0) ? 366 : 365;
    end
    for (int unsigned mm = 0; mm < m; mm++) begin
      d += fat_stamp_scoreboard::month_days(y, mm);
    end
    return d;
  endfunction

  function automatic bit [31:0] pick_epoch();
    longint unsigned secs;
    case ($urandom_range(0, 3))
      0: begin
        secs = longint'($urandom_range(0, LAST_DAY)) * SECS_PER_DAY;
        case ($urandom_range(0, 3))
          0: secs += SECS_PER_DAY - 1;
          1: secs += $urandom_range(0, 1);
          2: secs += SECS_PER_DAY - 1 - $urandom_range(0, 3599);
          default: secs += $urandom_range(0, SECS_PER_DAY - 1);
        endcase
      end
      1: begin
        secs = month_start_day($urandom_range(s2f_pkg::BASE_YEAR, 2086),
                               $urandom_range(0, s2f_pkg::MON_DEC)) * SECS_PER_DAY;
        case ($urandom_range(0, 2))
          0: secs = (secs == 0) ? 0 : secs - 1;
          1: secs += $urandom_range(0, 59);
          default: secs += $urandom_range(0, SECS_PER_DAY - 1);
        endcase
      end
      default: secs = $urandom;
    endcase
    if (secs > 64'hFFFF_FFFF) begin
      secs = $urandom;
    end
    return secs[31:0];
  endfunction

  task automatic wait_until_drained();
    stamp_in.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic offer_request(bit [31:0] secs);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      stamp_in.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    stamp_in.valid         = 1'b1;
    stamp_in.epoch_seconds = secs;
    do @(posedge clk); while (!stamp_in.ready);
    @(negedge clk);
    requests_sent++;
    idling_on = (requests_sent < 600 || requests_sent > 750) && requests_sent < 1500;
    if (requests_sent == 400) begin
      hold_request = 1'b1;
    end
    if (requests_sent == 800 || requests_sent == 1200) begin
      wait_until_drained();
    end
  endtask

  initial begin
    bit [31:0] directed_q[$];
    directed_q = '{
      32'd0, 32'hFFFF_FFFF, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
      32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
      32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
      32'd94607999, 32'd946684799, 32'd946684800, 32'd1582934400,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };
    requests_sent          = 0;
    idling_on              = 1'b1;
    hold_request           = 1'b0;
    stamp_in.valid         = 1'b0;
    stamp_in.epoch_seconds = '0;
    @(negedge clk);
    while (rst) @(negedge clk);
    foreach (directed_q[i]) begin
      offer_request(directed_q[i]);
    end
    while (requests_sent < TOTAL_REQUESTS) begin
      offer_request(pick_epoch());
    end
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
